FILE: hw/rtl/set_assoc_cache_tag_lookup_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache tag lookup
// Shared helpers for concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_DEFINES_SVH

// same-cycle implication
`define SACTL_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define SACTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/sactl_pkg.sv
// ----------------------------------------------------------------------------
// sactl_pkg
// Geometry, codes and line types of the cache tag lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sactl_pkg;

  localparam int MAX_SETS  = 256;
  localparam int MAX_WAYS  = 4;
  localparam int ADDR_BITS = 48;
  localparam int SET_BITS  = $clog2(MAX_SETS);
  localparam int WAY_BITS  = $clog2(MAX_WAYS);
  localparam int TAG_BITS  = 48;
  localparam int CNT_BITS  = 32;
  localparam int LSH_BITS  = 4;
  localparam int SCL_BITS  = 4;
  localparam int WCL_BITS  = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 4;

  // request codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_SIZE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SET_COUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WAY_COUNT = 2'd2;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic                valid;
    logic                recent;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  localparam int ROW_BITS = $bits(row_t);

endpackage

FILE: hw/rtl/sactl_ram.sv
// ----------------------------------------------------------------------------
// sactl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sactl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/set_assoc_cache_tag_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Tag array of a set-associative cache with recently-used replacement and
// saturating read / write / miss counters.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  request  | start, busy               | operation, address
//  result   | done (one-cycle strobe)   | hit, set_index, line_tag, counters
//  config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
//  Read / write: address split, row read from the set RAM, one tag compare
//  per way on a single shared comparator (stops at the first match), row
//  write-back. Busy meanwhile. Flush / clear statistics: done in the cycle
//  after accept; flush clears the per-set row-valid flags at once, so no
//  clearing pass follows reset. Config transfers only while idle and no
//  request is offered (cfg_ready). Reset is synchronous; results cannot be
//  stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_lookup_defines.svh"

module set_assoc_cache_tag_lookup (
  input  logic                                 clk,
  input  logic                                 rst,
  // request
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           operation,
  input  logic [sactl_pkg::ADDR_BITS-1:0]      address,
  // result
  output logic                                 done,
  output logic                                 hit,
  output logic [sactl_pkg::SET_BITS-1:0]       set_index,
  output logic [sactl_pkg::TAG_BITS-1:0]       line_tag,
  output logic [sactl_pkg::CNT_BITS-1:0]       reads_seen,
  output logic [sactl_pkg::CNT_BITS-1:0]       read_misses,
  output logic [sactl_pkg::CNT_BITS-1:0]       writes_seen,
  output logic [sactl_pkg::CNT_BITS-1:0]       write_misses,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sactl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [sactl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import sactl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  logic [1:0]          state;
  logic [1:0]          op_q;
  logic [LSH_BITS-1:0] line_size_log2;
  logic [SCL_BITS-1:0] set_count_log2;
  logic [WCL_BITS-1:0] way_count_log2;

  logic [SET_BITS-1:0] set_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [WAY_BITS-1:0] way_q;
  logic [WAY_BITS-1:0] way_last;
  logic [WAY_BITS-1:0] chosen;
  logic                found;
  logic                row_ok_q;
  logic [MAX_SETS-1:0] row_ok;

  logic                accept;
  logic [SCL_BITS-1:0] sbits;
  logic [WCL_BITS-1:0] wlog;
  logic [4:0]          tag_shamt;
  logic [ADDR_BITS-1:0] line_addr;
  logic [ADDR_BITS-1:0] tag_full;
  logic [SET_BITS-1:0] set_mask;
  logic [SET_BITS-1:0] set_calc;

  logic [ROW_BITS-1:0] ram_rdata;
  row_t                row;
  row_t                new_row;
  line_t               cur_line;
  logic                way_match;
  logic [WAY_BITS-1:0] free_way;
  logic                free_found;
  logic [WAY_BITS-1:0] fill_way;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  // geometry only changes between requests
  assign cfg_ready = !busy && !start;
  assign set_index = set_r;
  assign line_tag  = tag_r;

  // geometry clamped to the array size
  always_comb begin
    sbits    = (set_count_log2 > SCL_BITS'(SET_BITS)) ? SCL_BITS'(SET_BITS) : set_count_log2;
    wlog     = (way_count_log2 > WCL_BITS'(WAY_BITS)) ? WCL_BITS'(WAY_BITS) : way_count_log2;
    way_last = WAY_BITS'((1 << wlog) - 1);
  end

  // address split
  always_comb begin
    tag_shamt = {1'b0, line_size_log2} + 5'(sbits);
    line_addr = address >> line_size_log2;
    tag_full  = address >> tag_shamt;
    set_mask  = ~({SET_BITS{1'b1}} << sbits);
    set_calc  = line_addr[SET_BITS-1:0] & set_mask;
  end

  // set RAM: one row holds every way of a set
  sactl_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (MAX_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (state == S_WR),
    .waddr (set_r),
    .wdata (new_row),
    .re    (state == S_RD),
    .raddr (set_r),
    .rdata (ram_rdata)
  );

  // a row not written since reset or flush reads as all zero
  assign row = row_ok_q ? row_t'(ram_rdata) : '0;

  // shared tag comparator, one way per cycle
  always_comb begin
    cur_line  = row[way_q];
    way_match = cur_line.valid && (cur_line.tag == tag_r);
  end

  // victim: lowest way in use with a clear recent bit, else way 0
  always_comb begin
    free_way   = '0;
    free_found = 1'b0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!free_found && (WAY_BITS'(w) <= way_last) && !row[w].recent) begin
        free_found = 1'b1;
        free_way   = WAY_BITS'(w);
      end
    end
    fill_way = found ? chosen : free_way;
  end

  // updated row for write-back
  always_comb begin
    new_row = row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_BITS'(w) <= way_last) begin
        new_row[w].recent = (WAY_BITS'(w) == fill_way);
      end
    end
    if (!found) begin
      new_row[fill_way].valid = 1'b1;
      new_row[fill_way].tag   = tag_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_size_log2 <= LSH_BITS'(6);
      set_count_log2 <= SCL_BITS'(8);
      way_count_log2 <= WCL_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINE_SIZE: line_size_log2 <= cfg_data[LSH_BITS-1:0];
        REG_SET_COUNT: set_count_log2 <= cfg_data[SCL_BITS-1:0];
        REG_WAY_COUNT: way_count_log2 <= cfg_data[WCL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, counters and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      hit          <= 1'b0;
      row_ok       <= '0;
      reads_seen   <= '0;
      read_misses  <= '0;
      writes_seen  <= '0;
      write_misses <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q <= operation;
            if (operation == OP_READ || operation == OP_WRITE) begin
              set_r <= set_calc;
              tag_r <= tag_full[TAG_BITS-1:0];
              state <= S_RD;
            end else begin
              set_r <= '0;
              tag_r <= '0;
              hit   <= 1'b0;
              done  <= 1'b1;
              if (operation == OP_FLUSH) begin
                row_ok <= '0;
              end else begin
                reads_seen   <= '0;
                read_misses  <= '0;
                writes_seen  <= '0;
                write_misses <= '0;
              end
            end
          end
        end
        S_RD: begin
          row_ok_q <= row_ok[set_r];
          way_q    <= '0;
          found    <= 1'b0;
          chosen   <= '0;
          state    <= S_CMP;
        end
        S_CMP: begin
          if (way_match) begin
            found  <= 1'b1;
            chosen <= way_q;
            state  <= S_WR;
          end else if (way_q == way_last) begin
            state <= S_WR;
          end else begin
            way_q <= way_q + 1'b1;
          end
        end
        S_WR: begin
          row_ok[set_r] <= 1'b1;
          hit           <= found;
          done          <= 1'b1;
          state         <= S_IDLE;
          if (op_q == OP_READ) begin
            if (reads_seen != CNT_MAX) reads_seen <= reads_seen + 1'b1;
            if (!found && read_misses != CNT_MAX) read_misses <= read_misses + 1'b1;
          end else begin
            if (writes_seen != CNT_MAX) writes_seen <= writes_seen + 1'b1;
            if (!found && write_misses != CNT_MAX) write_misses <= write_misses + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `SACTL_ASSERT_NEXT(a_wr_then_done, clk, rst, state == S_WR, done && !busy)
  `SACTL_ASSERT_IMPL(a_way_in_range, clk, rst, state == S_CMP, way_q <= way_last)
  `SACTL_ASSERT_IMPL(a_maint_zero, clk, rst, done && (op_q == OP_FLUSH || op_q == OP_CLEAR), !hit && set_index == '0 && line_tag == '0)

endmodule

FILE: sim/set_assoc_cache_tag_lookup_checker.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_checker
// Watches the request, result and configuration channels of the cache tag
// lookup, keeps its own copy of the tag array, recent bits and counters, and
// compares every result strobe field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_assoc_cache_tag_lookup_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  // request
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [1:0]                           operation,
  input  logic [sactl_pkg::ADDR_BITS-1:0]      address,
  // result
  input  logic                                 done,
  input  logic                                 hit,
  input  logic [sactl_pkg::SET_BITS-1:0]       set_index,
  input  logic [sactl_pkg::TAG_BITS-1:0]       line_tag,
  input  logic [sactl_pkg::CNT_BITS-1:0]       reads_seen,
  input  logic [sactl_pkg::CNT_BITS-1:0]       read_misses,
  input  logic [sactl_pkg::CNT_BITS-1:0]       writes_seen,
  input  logic [sactl_pkg::CNT_BITS-1:0]       write_misses,
  // configuration
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [sactl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [sactl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // status toward the testbench top
  output int                                   fail_count,
  output int                                   pending
);

  import sactl_pkg::*;

  localparam int LINES = MAX_SETS * MAX_WAYS;

  typedef struct {
    bit                  hit;
    logic [SET_BITS-1:0] set_index;
    logic [TAG_BITS-1:0] line_tag;
    logic [CNT_BITS-1:0] reads_seen;
    logic [CNT_BITS-1:0] read_misses;
    logic [CNT_BITS-1:0] writes_seen;
    logic [CNT_BITS-1:0] write_misses;
  } lookup_result_t;

  // predicted cache state
  logic [TAG_BITS-1:0] line_tags [LINES];
  bit                  line_valid [LINES];
  bit                  line_recent [LINES];
  logic [CNT_BITS-1:0] rd_count, rd_miss_count, wr_count, wr_miss_count;

  // geometry registers
  logic [LSH_BITS-1:0] line_log2;
  logic [SCL_BITS-1:0] sets_log2;
  logic [WCL_BITS-1:0] ways_log2;

  lookup_result_t expected_results [$];
  int             errors = 0;

  assign fail_count = errors;

  // largest log2 not above the request whose power of two fits the limit
  function automatic int unsigned fit_log2(input int unsigned req, input int unsigned limit);
    int unsigned s;
    s = req & 15;
    while (s > 0 && (1 << s) > limit) s--;
    return s;
  endfunction

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  task automatic flush_lines();
    for (int i = 0; i < LINES; i++) begin
      line_tags[i]   = '0;
      line_valid[i]  = 1'b0;
      line_recent[i] = 1'b0;
    end
  endtask

  task automatic clear_counters();
    rd_count      = '0;
    rd_miss_count = '0;
    wr_count      = '0;
    wr_miss_count = '0;
  endtask

  // apply one request to the predicted state and queue its result
  task automatic predict_lookup(input logic [1:0] op, input logic [ADDR_BITS-1:0] addr);
    lookup_result_t r;
    int unsigned    sb, ways, base, chosen;
    logic [63:0]    set_full, tag_full;
    bit             found, free_found;
    r = '{default: '0};
    case (op)
      OP_READ, OP_WRITE: begin
        sb       = fit_log2(sets_log2, MAX_SETS);
        ways     = 1 << fit_log2(ways_log2, MAX_WAYS);
        set_full = (64'(addr) >> line_log2) & ((64'd1 << sb) - 64'd1);
        tag_full = 64'(addr) >> (line_log2 + sb);
        base     = 32'(set_full[SET_BITS-1:0]) * MAX_WAYS;
        found    = 1'b0;
        chosen   = 0;
        // lowest-numbered valid matching way wins
        for (int w = 0; w < ways && !found; w++) begin
          if (line_valid[base+w] && line_tags[base+w] == tag_full[TAG_BITS-1:0]) begin
            found  = 1'b1;
            chosen = w;
          end
        end
        // miss: first way with a clear recent bit, way 0 if none
        if (!found) begin
          free_found = 1'b0;
          for (int w = 0; w < ways && !free_found; w++) begin
            if (!line_recent[base+w]) begin
              free_found = 1'b1;
              chosen     = w;
            end
          end
          if (!free_found) chosen = 0;
          line_valid[base+chosen] = 1'b1;
          line_tags[base+chosen]  = tag_full[TAG_BITS-1:0];
        end
        for (int w = 0; w < ways; w++) line_recent[base+w] = (w == chosen);
        if (op == OP_READ) begin
          rd_count = sat_inc(rd_count);
          if (!found) rd_miss_count = sat_inc(rd_miss_count);
        end else begin
          wr_count = sat_inc(wr_count);
          if (!found) wr_miss_count = sat_inc(wr_miss_count);
        end
        r.hit       = found;
        r.set_index = set_full[SET_BITS-1:0];
        r.line_tag  = tag_full[TAG_BITS-1:0];
      end
      OP_FLUSH: flush_lines();
      default:  clear_counters();
    endcase
    r.reads_seen   = rd_count;
    r.read_misses  = rd_miss_count;
    r.writes_seen  = wr_count;
    r.write_misses = wr_miss_count;
    expected_results.push_back(r);
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (rst) begin
      line_log2 = 4'd6;
      sets_log2 = 4'd8;
      ways_log2 = 2'd1;
      flush_lines();
      clear_counters();
      expected_results.delete();
    end else begin
      // register write transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LINE_SIZE: line_log2 = cfg_data;
          REG_SET_COUNT: sets_log2 = cfg_data;
          REG_WAY_COUNT: ways_log2 = cfg_data[WCL_BITS-1:0];
          default: ;
        endcase
      end
      // result strobe against the oldest prediction
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual hit=%0d set=0x%0h tag=0x%0h",
                   $time, hit, set_index, line_tag);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          compare_field("hit", exp_r.hit, hit);
          compare_field("set_index", exp_r.set_index, set_index);
          compare_field("line_tag", exp_r.line_tag, line_tag);
          compare_field("reads_seen", exp_r.reads_seen, reads_seen);
          compare_field("read_misses", exp_r.read_misses, read_misses);
          compare_field("writes_seen", exp_r.writes_seen, writes_seen);
          compare_field("write_misses", exp_r.write_misses, write_misses);
        end
      end
      // request transfer
      if (start && !busy) predict_lookup(operation, address);
    end
    pending <= expected_results.size();
  end

endmodule

FILE: sim/tb_set_assoc_cache_tag_lookup.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_lookup
// Drives reads, writes, flushes and statistics clears into the cache tag
// lookup under a series of line / set / way geometries, with bursty request
// timing. A directed opening covers the corner cases; random phases then
// hammer small address pools so that hits, conflicts and evictions are common.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_lookup;
  import sactl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 150;
  localparam int POOL_SIZE = 10;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               operation;
  logic [ADDR_BITS-1:0]     address;
  logic                     done;
  logic                     hit;
  logic [SET_BITS-1:0]      set_index;
  logic [TAG_BITS-1:0]      line_tag;
  logic [CNT_BITS-1:0]      reads_seen, read_misses, writes_seen, write_misses;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int                       fail_count;
  int                       pending;
  int                       cycle_count = 0;

  // geometry currently programmed, used to aim addresses at few sets
  int unsigned cur_lsh = 6;
  int unsigned cur_sb = 8;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  set_assoc_cache_tag_lookup i_dut (
    .clk, .rst,
    .start, .busy, .operation, .address,
    .done, .hit, .set_index, .line_tag,
    .reads_seen, .read_misses, .writes_seen, .write_misses,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  set_assoc_cache_tag_lookup_checker i_checker (
    .clk, .rst,
    .start, .busy, .operation, .address,
    .done, .hit, .set_index, .line_tag,
    .reads_seen, .read_misses, .writes_seen, .write_misses,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one request transfer; start stays high when no gap follows
  task automatic send_request(input logic [1:0] op, input logic [ADDR_BITS-1:0] addr,
                              input int gap);
    start     <= 1'b1;
    operation <= op;
    address   <= addr;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all outstanding results and let the block go quiet
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // back-to-back register writes, valid held high across the transfers
  task automatic program_geometry(input logic [3:0] ls, input logic [3:0] sc,
                                  input logic [1:0] wc, input bit poke_unused);
    logic [CFG_IDX_BITS-1:0]  idx [4];
    logic [CFG_DATA_BITS-1:0] val [4];
    int                       n;
    n = 0;
    if (poke_unused) begin
      idx[n] = REG_UNUSED;
      val[n] = 4'($urandom_range(0, 15));
      n++;
    end
    idx[n] = REG_LINE_SIZE; val[n] = ls; n++;
    idx[n] = REG_SET_COUNT; val[n] = sc; n++;
    // upper data bits are don't-care for the way register
    idx[n] = REG_WAY_COUNT; val[n] = {2'($urandom_range(0, 3)), wc}; n++;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_lsh = ls;
    cur_sb  = (sc > 8) ? 8 : sc;
  endtask

  task automatic run_directed();
    // reset geometry: 64-byte lines, 256 sets, 2 ways
    send_request(OP_READ, 48'h0, 0);                  // cold miss
    send_request(OP_READ, 48'h3F, 1);                 // same line, hit
    send_request(OP_WRITE, 48'hFFFF_FFFF_FFFF, 0);    // top address
    send_request(OP_READ, 48'hFFFF_FFFF_FFFF, 2);
    send_request(OP_READ, 48'h1 << 14, 0);            // set 0 conflicts
    send_request(OP_READ, 48'h2 << 14, 0);
    send_request(OP_READ, 48'h0, 1);
    send_request(OP_WRITE, 48'h2 << 14, 0);
    send_request(OP_FLUSH, 48'hFFFF_FFFF_FFFF, 0);
    send_request(OP_READ, 48'h0, 0);                  // miss after flush
    send_request(OP_CLEAR, 48'h5555_5555_5555, 0);
    send_request(OP_WRITE, 48'h0, 0);
    send_request(OP_WRITE, 48'h5555_5555_5555, 0);
    send_request(OP_READ, 48'hAAAA_AAAA_AAAA, 0);
    settle();

    // 4096-byte lines, one set, one way: replacement always lands on way 0
    program_geometry(4'd12, 4'd0, 2'd0, 1'b0);
    send_request(OP_READ, 48'h123, 0);
    send_request(OP_READ, 48'h123, 0);
    send_request(OP_READ, 48'h1000, 0);
    settle();

    // oversized sets and ways get clipped to the array size
    program_geometry(4'd0, 4'd15, 2'd3, 1'b1);
    for (int k = 0; k < 5; k++) send_request(OP_READ, 48'(k) << 8, 0);
    send_request(OP_READ, 48'h0, 0);
    settle();

    // two ways holding the same tag after a way-count change
    program_geometry(4'd6, 4'd8, 2'd1, 1'b0);
    send_request(OP_FLUSH, 48'h0, 0);
    send_request(OP_READ, 48'h5 << 14, 0);
    send_request(OP_READ, 48'h7 << 14, 0);
    settle();
    program_geometry(4'd6, 4'd8, 2'd0, 1'b0);
    send_request(OP_READ, 48'h7 << 14, 0);
    settle();
    program_geometry(4'd6, 4'd8, 2'd1, 1'b0);
    send_request(OP_READ, 48'h7 << 14, 0);
  endtask

  task automatic run_random();
    logic [ADDR_BITS-1:0] pool [POOL_SIZE];
    logic [ADDR_BITS-1:0] addr, tag_part;
    logic [1:0]           op;
    int                   burst_left, gap, pick;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       program_geometry(4'd0, 4'd0, 2'd0, 1'b0);
        1:       program_geometry(4'd15, 4'd15, 2'd3, 1'b1);
        2:       program_geometry(4'd12, 4'd8, 2'd2, 1'b0);
        3:       program_geometry(4'd0, 4'd8, 2'd2, 1'b0);
        default: program_geometry(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                  2'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0));
      endcase
      // few tags over few sets so hits and evictions dominate
      for (int k = 0; k < POOL_SIZE; k++) begin
        tag_part = ($urandom_range(0, 9) < 6) ? 48'($urandom_range(0, 3))
                                               : 48'({$urandom, $urandom});
        pool[k] = (tag_part << (cur_lsh + cur_sb))
                | (48'($urandom_range(0, 3)) << cur_lsh);
      end
      burst_left = 0;
      gap        = 0;
      repeat (PHASE_ITEMS) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        pick = $urandom_range(0, 99);
        if (pick < 46)      op = OP_READ;
        else if (pick < 93) op = OP_WRITE;
        else if (pick < 95) op = OP_FLUSH;
        else                op = OP_CLEAR;
        if ($urandom_range(0, 99) < 85)
          addr = pool[$urandom_range(0, POOL_SIZE - 1)]
               | 48'({$urandom, $urandom} & ((64'd1 << cur_lsh) - 64'd1));
        else
          addr = 48'({$urandom, $urandom});
        send_request(op, addr, (burst_left == 0) ? gap : 0);
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    operation = OP_READ;
    address   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LINE_SIZE;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    settle();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
